// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert an implication, clocked on clk, disabled in reset
`define AST_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// assert a condition on every clock outside reset
`define AST_ALW(label, clk, rst_n, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- rtl/tpa_pkg.sv -----
// ----------------------------------------------------------------------------
// tpa_pkg: shared types and constants for the tilt posture alarm
// Holds widths, register map, CORDIC arctangent table and the queue entry.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax     = 24;
    localparam int AngleLimit         = 1440;
    localparam int MsPerMin           = 60000;
    localparam int MsPerSec           = 1000;

    localparam logic [1:0] REG_HIGH_TH   = 2'd0;
    localparam logic [1:0] REG_LOW_TH    = 2'd1;
    localparam logic [1:0] REG_SAVE_INT  = 2'd2;
    localparam logic [1:0] REG_LOG_LIMIT = 2'd3;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               calibrate;
        logic [31:0]        now_ms;
    } sample_t;

    typedef struct packed {
        logic [11:0] high_threshold;
        logic [11:0] low_threshold;
        logic [31:0] save_interval_ms;
        logic [9:0]  log_limit;
    } cfg_t;

    // queue entry from the angle front end to the alarm back end
    typedef struct packed {
        logic signed [11:0] angle;
        logic               calibrate;
        logic [31:0]        now_ms;
    } angle_item_t;

    typedef struct packed {
        logic signed [12:0] deviation;
        logic               led_on;
        logic               vibrate;
        logic               event_valid;
        logic [16:0]        event_minutes;
        logic [5:0]         event_seconds;
        logic signed [12:0] event_deviation;
        logic               flush;
    } result_t;

    function automatic logic [22:0] atan_entry(input logic [4:0] i);
        logic [22:0] r;
        begin
            unique case (i)
                5'd0:  r = 23'd2949120;
                5'd1:  r = 23'd1740967;
                5'd2:  r = 23'd919879;
                5'd3:  r = 23'd466945;
                5'd4:  r = 23'd234379;
                5'd5:  r = 23'd117304;
                5'd6:  r = 23'd58666;
                5'd7:  r = 23'd29335;
                5'd8:  r = 23'd14668;
                5'd9:  r = 23'd7334;
                5'd10: r = 23'd3667;
                5'd11: r = 23'd1833;
                5'd12: r = 23'd917;
                5'd13: r = 23'd458;
                5'd14: r = 23'd229;
                5'd15: r = 23'd115;
                5'd16: r = 23'd57;
                5'd17: r = 23'd29;
                5'd18: r = 23'd14;
                5'd19: r = 23'd7;
                5'd20: r = 23'd4;
                5'd21: r = 23'd2;
                5'd22: r = 23'd1;
                default: r = 23'd0;
            endcase
            atan_entry = r;
        end
    endfunction

endpackage

// ----- rtl/tpa_angle.sv -----
// ----------------------------------------------------------------------------
// tpa_angle: pitch front end
// Squares, takes a bit-serial square root and runs an iterative CORDIC to
// give the pitch in 1/16 degree for one sample at a time.
// ----------------------------------------------------------------------------
module tpa_angle
    import tpa_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sample_t     in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output angle_item_t out_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_CORD = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // radius*256 < 2^24; CORDIC growth stays below 2^26
    localparam int XW = 28;
    localparam int AW = 26;

    logic [2:0]          state_reg, state_next;
    sample_t             smp_reg;
    logic [31:0]         sqx_reg, sqz_reg;
    logic [47:0]         rem_reg;
    logic [24:0]         root_reg;
    logic [4:0]          cnt_reg;
    logic signed [XW-1:0] xv_reg, yv_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [11:0]  ang_reg;
    logic                zero_in_reg;

    // one square-root digit per cycle on the 48-bit radicand, two bits a step
    logic [49:0] rad;
    logic [47:0] trial_rem;
    logic [26:0] trial;
    logic        take;

    logic signed [XW-1:0] dx, dy;
    logic [22:0]          atab;
    logic signed [AW-1:0] acc_neg, rnd;
    logic signed [13:0]   r14;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_item.angle     = ang_reg;
    assign out_item.calibrate = smp_reg.calibrate;
    assign out_item.now_ms    = smp_reg.now_ms;

    // radicand is (x^2+z^2)<<16, below 2^48
    logic [31:0] sqsum;
    logic [47:0] radicand;
    logic [47:0] rad_shift;
    assign sqsum    = sqx_reg + sqz_reg;
    assign radicand = {sqsum, 16'd0};

    // digit pair for step cnt: radicand bits [2k+1:2k], k = 23 - cnt
    logic [5:0]  pos;
    logic [1:0]  pair;
    assign pos       = 6'd46 - {cnt_reg, 1'b0};
    assign rad_shift = radicand >> pos;
    assign pair      = rad_shift[1:0];
    assign rad       = {rem_reg, pair};
    assign trial     = {root_reg[24:0], 2'b01};
    assign take      = (rad >= {23'd0, trial});
    assign trial_rem = take ? (rad[47:0] - 48'(trial)) : rad[47:0];

    assign dx   = yv_reg >>> cnt_reg;
    assign dy   = xv_reg >>> cnt_reg;
    assign atab = atan_entry(cnt_reg);
    assign acc_neg = -acc_reg;
    assign rnd     = (acc_neg + AW'(2048)) >>> 12;
    assign r14     = rnd[13:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == 5'd24) state_next = ST_CORD;
            ST_CORD: if (cnt_reg == 5'(CORDIC_STEPS)) state_next = ST_DONE;
            ST_DONE: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) smp_reg <= in_item;
            end
            ST_SQ:
            begin
                sqx_reg  <= 32'(smp_reg.accel_x) * 32'(smp_reg.accel_x);
                sqz_reg  <= 32'(smp_reg.accel_z) * 32'(smp_reg.accel_z);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                // zero check must see the inputs, not the rotated vector
                zero_in_reg <= (smp_reg.accel_x == 0) && (smp_reg.accel_y == 0)
                    && (smp_reg.accel_z == 0);
            end
            ST_ROOT:
            begin
                if (cnt_reg == 5'd24)
                begin
                    // seed CORDIC with (r, y*256); cnt is now the iteration index
                    xv_reg  <= XW'(root_reg);
                    yv_reg  <= XW'(smp_reg.accel_y) <<< 8;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    rem_reg  <= trial_rem;
                    root_reg <= {root_reg[23:0], take};
                    cnt_reg  <= cnt_reg + 5'd1;
                end
            end
            ST_CORD:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS))
                begin
                    if (zero_in_reg)
                        ang_reg <= '0;
                    else if (r14 > 14'sd1440)
                        ang_reg <= 12'sd1440;
                    else if (r14 < -14'sd1440)
                        ang_reg <= -12'sd1440;
                    else
                        ang_reg <= r14[11:0];
                end
                else
                begin
                    if (yv_reg > 0)
                    begin
                        xv_reg  <= xv_reg + dx;
                        yv_reg  <= yv_reg - dy;
                        acc_reg <= acc_reg + AW'(atab);
                    end
                    else
                    begin
                        xv_reg  <= xv_reg - dx;
                        yv_reg  <= yv_reg + dy;
                        acc_reg <= acc_reg - AW'(atab);
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/tpa_alarm.sv -----
// ----------------------------------------------------------------------------
// tpa_alarm: alarm back end
// Applies calibration, hysteresis, event logging and flush timing.
// ----------------------------------------------------------------------------
module tpa_alarm
    import tpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  angle_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TIME = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_SEC  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // ceil(2^47 / 60000): exact quotient for any 32-bit time
    localparam logic [31:0] MinRecip = 32'd2345624806;
    // ceil(2^26 / 1000): exact quotient for remainders below one minute
    localparam logic [31:0] SecRecip = 32'd67109;

    logic [2:0]         state_reg;
    angle_item_t        itm_reg;
    logic signed [11:0] zero_reg;
    logic               cal_reg, outside_reg, vib_reg;
    logic [9:0]         pend_reg;
    logic [31:0]        last_reg;
    result_t            res_reg;
    logic [16:0]        min_reg;
    logic [15:0]        msrem_reg;

    logic signed [11:0] zero_use;
    logic signed [12:0] dev;
    logic               cal_use, hi, lo, ev, fl;
    logic [9:0]         pend_a, pend_b;
    logic [31:0]        last_a;
    logic               outside_n, vib_n;

    // now/60000 by reciprocal multiply; the remainder is registered in ST_REM and the seconds in ST_SEC
    logic [63:0] q_prod;
    logic [16:0] q_est;
    logic [31:0] q_rem;
    logic [31:0] sec_prod;
    logic [5:0]  sec_w;
    assign q_prod   = {32'd0, itm_reg.now_ms} * {32'd0, MinRecip};
    assign q_est    = q_prod[63:47];
    assign q_rem    = itm_reg.now_ms - 32'(min_reg) * 32'(MsPerMin);
    assign sec_prod = 32'(msrem_reg) * SecRecip;
    assign sec_w    = sec_prod[31:26];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_item  = res_reg;

    assign cal_use  = cal_reg | itm_reg.calibrate;
    assign zero_use = itm_reg.calibrate ? itm_reg.angle : zero_reg;
    assign dev      = 13'(itm_reg.angle) - 13'(zero_use);
    assign hi       = dev > $signed({1'b0, cfg.high_threshold});
    assign lo       = dev < $signed({1'b0, cfg.low_threshold});

    always_comb
    begin
        ev = 1'b0;
        fl = 1'b0;
        pend_a = pend_reg;
        last_a = last_reg;
        outside_n = outside_reg;
        vib_n = vib_reg;
        if (cal_use)
        begin
            if (hi)
            begin
                vib_n = 1'b1;
                if (!outside_reg)
                begin
                    outside_n = 1'b1;
                    if (pend_a < cfg.log_limit)
                    begin
                        ev = 1'b1;
                        pend_a = pend_a + 10'd1;
                    end
                    if (pend_a >= cfg.log_limit)
                    begin
                        if (pend_a != 0) fl = 1'b1;
                        pend_a = '0;
                        last_a = itm_reg.now_ms;
                    end
                end
            end
            else if (lo)
            begin
                vib_n = 1'b0;
                outside_n = 1'b0;
            end
        end
        pend_b = pend_a;
        if (cal_use && ((itm_reg.now_ms - last_a) >= cfg.save_interval_ms))
        begin
            if (pend_a != 0) fl = 1'b1;
            pend_b = '0;
            last_a = itm_reg.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            itm_reg     <= '0;
            zero_reg    <= '0;
            cal_reg     <= 1'b0;
            outside_reg <= 1'b0;
            vib_reg     <= 1'b0;
            pend_reg    <= '0;
            last_reg    <= '0;
            res_reg     <= '0;
            min_reg     <= '0;
            msrem_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        itm_reg   <= in_item;
                        state_reg <= ST_TIME;
                    end
                end
                ST_TIME:
                begin
                    min_reg   <= q_est;
                    zero_reg  <= zero_use;
                    cal_reg   <= cal_use;
                    outside_reg <= outside_n;
                    vib_reg   <= vib_n;
                    pend_reg  <= pend_b;
                    last_reg  <= last_a;
                    res_reg.deviation   <= dev;
                    res_reg.led_on      <= itm_reg.calibrate;
                    res_reg.vibrate     <= vib_n;
                    res_reg.event_valid <= ev;
                    res_reg.event_deviation <= ev ? dev : '0;
                    res_reg.flush       <= fl;
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    msrem_reg <= q_rem[15:0];
                    state_reg <= ST_SEC;
                end
                ST_SEC:
                begin
                    res_reg.event_minutes <= res_reg.event_valid ? min_reg : '0;
                    res_reg.event_seconds <= res_reg.event_valid ? sec_w : '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/tilt_posture_alarm.sv -----
// Order of work per sample: square, root digits, CORDIC seed, CORDIC_STEPS
// rotations, round, queue load, then the back end accepts, runs the alarm,
// registers the remainder and the seconds. The front end takes a new sample
// only after it has handed the previous one on; the back end sits behind a
// one-entry queue, and a stall there holds the front end once the queue is full.
// Reset: asynchronous active low, registers return to defaults except front-end datapath and queue data.
// ----------------------------------------------------------------------------
// tilt_posture_alarm: accelerometer pitch with hysteresis alarm and event log
// Front end computes pitch, back end drives vibrator, events and flush.
// ----------------------------------------------------------------------------
module tilt_posture_alarm
    import tpa_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
    input  logic [79:0] s_tdata,
    // calibrate
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // deviation[12:0], event_minutes[29:13], event_seconds[35:30],
    // event_deviation[48:36], zeros above
    output logic [55:0] m_tdata,
    // led_on[0], vibrate[1], event_valid[2], flush[3]
    output logic [3:0]  m_tuser
);

    cfg_t        cfg_reg;
    sample_t     smp;
    angle_item_t a_item, q_reg;
    logic        a_valid, a_ready, q_valid_reg, b_ready;
    result_t     res;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold   <= 12'd400;
            cfg_reg.low_threshold    <= 12'd320;
            cfg_reg.save_interval_ms <= 32'd20000;
            cfg_reg.log_limit        <= 10'd300;
        end
        else if (wr && paddr[1:0] == 2'b00 && paddr[3:2] == REG_HIGH_TH)
            cfg_reg.high_threshold <= pwdata[11:0];
        else if (wr && paddr[1:0] == 2'b00 && paddr[3:2] == REG_LOW_TH)
            cfg_reg.low_threshold <= pwdata[11:0];
        else if (wr && paddr[1:0] == 2'b00 && paddr[3:2] == REG_SAVE_INT)
            cfg_reg.save_interval_ms <= pwdata;
        else if (wr && paddr[1:0] == 2'b00 && paddr[3:2] == REG_LOG_LIMIT)
            cfg_reg.log_limit <= pwdata[9:0];
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HIGH_TH:   prdata = {20'd0, cfg_reg.high_threshold};
            REG_LOW_TH:    prdata = {20'd0, cfg_reg.low_threshold};
            REG_SAVE_INT:  prdata = cfg_reg.save_interval_ms;
            REG_LOG_LIMIT: prdata = {22'd0, cfg_reg.log_limit};
            default:       prdata = '0;
        endcase
    end

    assign smp.accel_x   = s_tdata[15:0];
    assign smp.accel_y   = s_tdata[31:16];
    assign smp.accel_z   = s_tdata[47:32];
    assign smp.now_ms    = s_tdata[79:48];
    assign smp.calibrate = s_tuser;

    tpa_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_angle (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(smp),
        .out_valid(a_valid), .out_ready(a_ready), .out_item(a_item)
    );

    // one-entry queue between front and back
    assign a_ready = !q_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (a_valid && a_ready)
            q_valid_reg <= 1'b1;
        else if (b_ready)
            q_valid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (a_valid && a_ready) q_reg <= a_item;
    end

    tpa_alarm u_alarm (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(q_valid_reg), .in_ready(b_ready), .in_item(q_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_item(res)
    );

    assign m_tdata = {7'd0, res.event_deviation, res.event_seconds,
                      res.event_minutes, res.deviation};
    assign m_tuser = {res.flush, res.event_valid, res.vibrate, res.led_on};

endmodule

// ----- rtl/tpa_checker.sv -----
// ----------------------------------------------------------------------------
// tpa_checker: port-level checks on the tilt posture alarm
// Watches output stability, result field consistency and that pready stays high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        pready
);

    `AST_IMP(a_hold, clk, rst_n, m_tvalid && !m_tready, ##1 $stable(m_tdata), "result changed under stall")
    `AST_IMP(a_evzero, clk, rst_n, m_tvalid && !m_tuser[2], m_tdata[48:13] == '0, "event fields set without event")
    `AST_IMP(a_evvib, clk, rst_n, m_tvalid && m_tuser[2], m_tuser[1], "event without vibrator on")
    `AST_ALW(a_ready, clk, rst_n, pready, "pready low")

endmodule

bind tilt_posture_alarm tpa_checker u_tpa_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tilt posture alarm
// Drives accelerometer samples over the input stream, predicts pitch,
// hysteresis, event log and flush per sample, and checks every result.
// ----------------------------------------------------------------------------
module tb
    import tpa_pkg::*;
();

    localparam int Steps = CordicStepsDefault;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;

    tilt_posture_alarm i_dut (.*);

    always #6 clk = ~clk;

    // configuration and alarm state mirror
    logic [11:0] high_th, low_th;
    logic [31:0] save_ms;
    logic [9:0]  log_lim;
    int          zero_ang;
    bit          is_cal, is_outside, vib_on;
    logic [9:0]  pending;
    logic [31:0] last_save;

    result_t expected_results[$];
    int      send_idle_pct, recv_idle_pct;
    bit      recv_hold;
    int      mismatches, results_seen, items_sent, events_seen, flushes_seen;

    // integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int pitch_sixteenths(input int x, input int y, input int z);
        longint xv, yv, acc, p, r, dx, dy;
        longint unsigned sq;
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
            2, 1, 0};
        sq = longint'(x) * x + longint'(z) * z;
        xv = longint'(root_floor(sq << 16));
        yv = longint'(y) * 256;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        for (int i = 0; i < Steps && i < 24; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv += dx;
                yv -= dy;
                acc += tab[i];
            end
            else
            begin
                xv -= dx;
                yv += dy;
                acc -= tab[i];
            end
        end
        p = -acc;
        r = (p + 2048) >>> 12;
        if (r > AngleLimit) r = AngleLimit;
        if (r < -AngleLimit) r = -AngleLimit;
        return int'(r);
    endfunction

    function automatic result_t predict_alarm(input sample_t s);
        result_t res;
        int ang, dev;
        ang = pitch_sixteenths(s.accel_x, s.accel_y, s.accel_z);
        res = '0;
        if (s.calibrate)
        begin
            zero_ang = ang;
            is_cal = 1'b1;
        end
        dev = ang - zero_ang;
        if (is_cal)
        begin
            if (dev > int'(high_th))
            begin
                vib_on = 1'b1;
                if (!is_outside)
                begin
                    is_outside = 1'b1;
                    if (pending < log_lim)
                    begin
                        res.event_valid = 1'b1;
                        res.event_minutes = 17'(s.now_ms / MsPerMin);
                        res.event_seconds = 6'((s.now_ms % MsPerMin) / MsPerSec);
                        res.event_deviation = 13'(dev);
                        pending = pending + 10'd1;
                    end
                    if (pending >= log_lim)
                    begin
                        if (pending != 0) res.flush = 1'b1;
                        pending = '0;
                        last_save = s.now_ms;
                    end
                end
            end
            else if (dev < int'(low_th))
            begin
                vib_on = 1'b0;
                is_outside = 1'b0;
            end
            if (32'(s.now_ms - last_save) >= save_ms)
            begin
                if (pending != 0) res.flush = 1'b1;
                pending = '0;
                last_save = s.now_ms;
            end
        end
        res.deviation = 13'(dev);
        res.led_on = s.calibrate;
        res.vibrate = vib_on;
        return res;
    endfunction

    // hold valid between back-to-back items; drop it only while idling
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.now_ms, s.accel_z, s.accel_y, s.accel_x};
        s_tuser <= s.calibrate;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(predict_alarm(s));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        paddr <= {idx, 2'b00};
        pwdata <= val;
        pwrite <= 1'b1;
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HIGH_TH:   high_th = val[11:0];
            REG_LOW_TH:    low_th = val[11:0];
            REG_SAVE_INT:  save_ms = val;
            REG_LOG_LIMIT: log_lim = val[9:0];
        endcase
        @(negedge clk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    function automatic sample_t make_sample(input int x, input int y, input int z,
                                            input bit cal, input logic [31:0] t);
        sample_t s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        s.calibrate = cal;
        s.now_ms = t;
        return s;
    endfunction

    // check results as they leave the block
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.deviation = m_tdata[12:0];
            got.event_minutes = m_tdata[29:13];
            got.event_seconds = m_tdata[35:30];
            got.event_deviation = m_tdata[48:36];
            got.led_on = m_tuser[0];
            got.vibrate = m_tuser[1];
            got.event_valid = m_tuser[2];
            got.flush = m_tuser[3];
            results_seen++;
            if (got.event_valid) events_seen++;
            if (got.flush) flushes_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[55:49] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    // receiver stalls; a long hold-off is counted here when requested
    always @(negedge clk)
    begin
        if (recv_hold)
        begin
            m_tready <= 1'b0;
            repeat (400) @(negedge clk);
            recv_hold = 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed;
        logic [31:0] t;
        t = 32'd5000;
        send_sample(make_sample(0, 0, 0, 0, t));
        send_sample(make_sample(-32768, -32768, -32768, 0, t));
        send_sample(make_sample(32767, 32767, 32767, 0, t));
        send_sample(make_sample(0, 32767, 0, 0, t));
        send_sample(make_sample(0, -32768, 0, 0, t));
        send_sample(make_sample(16384, 0, 0, 1, t));
        send_sample(make_sample(0, 0, 16384, 0, t + 100));
        send_sample(make_sample(0, -16384, 100, 0, t + 200));
        send_sample(make_sample(0, -16384, 100, 0, t + 300));
        send_sample(make_sample(16384, -5000, 0, 0, t + 400));
        send_sample(make_sample(16384, 0, 0, 0, t + 500));
        send_sample(make_sample(0, -16384, 0, 0, 32'hFFFF_FFFF));
        send_sample(make_sample(16384, 0, 0, 0, 32'd10));
        send_sample(make_sample(0, -16384, 0, 0, 32'd20));
        send_sample(make_sample(0, 0, 0, 1, 32'd20));
        send_sample(make_sample(-1, 1, -1, 0, 32'd30));
        drain();
    endtask

    task automatic test_config_corners;
        write_reg(REG_HIGH_TH, 32'hFFFF_F000);
        write_reg(REG_LOW_TH, 32'hFFF);
        write_reg(REG_SAVE_INT, 32'hFFFF_FFFF);
        write_reg(REG_LOG_LIMIT, 32'h3FF);
        for (int i = 0; i < 12; i++)
            send_sample(make_sample(16384, (i & 1) ? -16000 : 0, 0, i == 0, $urandom));
        drain();
        write_reg(REG_HIGH_TH, 32'd0);
        write_reg(REG_LOW_TH, 32'd0);
        write_reg(REG_SAVE_INT, 32'd1);
        write_reg(REG_LOG_LIMIT, 32'd1);
        for (int i = 0; i < 12; i++)
            send_sample(make_sample(16384, (i & 1) ? -16000 : 8000, 0, 0, $urandom));
        drain();
    endtask

    task automatic random_phase(input int count, input int s_idle, input int r_idle);
        int y;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_reg(REG_HIGH_TH, $urandom_range(600, 100));
        write_reg(REG_LOW_TH, $urandom_range(400, 0));
        write_reg(REG_SAVE_INT, $urandom_range(60000, 1));
        write_reg(REG_LOG_LIMIT, $urandom_range(12, 1));
        for (int i = 0; i < count; i++)
        begin
            // mostly swing between upright and tilted so crossings happen
            if ($urandom_range(9) < 7)
                y = ($urandom_range(1)) ? -$urandom_range(16000, 3000)
                                        : $urandom_range(3000, 0);
            else
                y = $signed(16'($urandom));
            send_sample(make_sample(($urandom_range(3) == 0) ? $signed(16'($urandom))
                                    : $urandom_range(16384, 8000),
                                    y, $signed(16'($urandom_range(2000))) - 1000,
                                    $urandom_range(49) == 0,
                                    items_sent * 937 + $urandom_range(900)));
            if (i == 20) recv_hold = 1'b1;
        end
        drain();
    endtask

    initial
    begin
        high_th = 12'd400;
        low_th = 12'd320;
        save_ms = 32'd20000;
        log_lim = 10'd300;
        zero_ang = 0;
        is_cal = 0;
        is_outside = 0;
        vib_on = 0;
        pending = '0;
        last_save = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_config_corners();
        random_phase(370, 36, 70);
        random_phase(370, 70, 36);
        random_phase(370, 0, 0);
        $display("tb: %0d samples, %0d results, %0d events, %0d flushes checked",
                 items_sent, results_seen, events_seen, flushes_seen);
        $display("tb: config extremes, calibration, hysteresis and time wrap covered");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
